// File: hw/rtl/sxfb_pkg.sv
`default_nettype none
package sxfb_pkg;

  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;

  localparam int COL_AW = $clog2(SCREEN_WIDTH);
  localparam int ROW_AW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

  localparam int MODE_W      = 3;
  localparam int COL_W       = 6;
  localparam int ROW_W       = 5;
  localparam int ROW_IDX_W   = 4;
  localparam int SPRITE_BITS = 8;
  localparam int ROW_TGT_W   = 6;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  localparam logic [7:0] SPRITE_MSB = 8'h80;

  localparam logic [6:0] WIDTH_LIM  = 7'(SCREEN_WIDTH);
  localparam logic [6:0] HEIGHT_LIM = 7'(SCREEN_HEIGHT);

  typedef enum logic [MODE_W-1:0] {
    MODE_DRAW   = 3'd0,
    MODE_SET    = 3'd1,
    MODE_INVERT = 3'd2,
    MODE_READ   = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_MODIFY
  } state_t;

  typedef struct packed {
    mode_t                  mode;
    logic [COL_W-1:0]       col;
    logic [ROW_W-1:0]       row;
    logic [ROW_IDX_W-1:0]   row_index;
    logic [SPRITE_BITS-1:0] sprite_row;
    logic                   pixel_value;
    logic                   last_row;
  } item_t;

  typedef struct packed {
    logic we;
    logic clr_all;
    logic pixel_out;
    logic done_res;
  } alu_ctl_t;

  // draw targets row + row_index, all other modes the row itself
  function automatic logic [ROW_TGT_W-1:0] row_target(input item_t it);
    logic [ROW_TGT_W-1:0] t;
    if (it.mode == MODE_DRAW) begin
      t = ROW_TGT_W'(it.row) + ROW_TGT_W'(it.row_index);
    end else begin
      t = ROW_TGT_W'(it.row);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sxfb_ram.sv
`default_nettype none
module sxfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: hw/rtl/sxfb_alu.sv
`default_nettype none
module sxfb_alu (
  input  wire sxfb_pkg::item_t                        item,
  input  wire logic [sxfb_pkg::SCREEN_WIDTH-1:0]      old_word,
  output logic      [sxfb_pkg::SCREEN_WIDTH-1:0]      new_word,
  output sxfb_pkg::alu_ctl_t                          ctl
);
  import sxfb_pkg::*;

  logic [ROW_TGT_W-1:0]    tgt;
  logic                    tgt_ok;
  logic                    pix_ok;
  logic [COL_AW-1:0]       col_idx;
  logic [SCREEN_WIDTH-1:0] pattern;
  logic [6:0]              pc;

  assign tgt     = row_target(item);
  assign tgt_ok  = 7'(tgt) < HEIGHT_LIM;
  assign pix_ok  = (7'(item.col) < WIDTH_LIM) && (7'(item.row) < HEIGHT_LIM);
  assign col_idx = item.col[COL_AW-1:0];

  // clipped sprite pattern, bit 7 at col
  always_comb begin
    pattern = '0;
    pc      = '0;
    for (int j = 0; j < SPRITE_BITS; j++) begin
      pc = 7'(item.col) + 7'(j);
      if (((item.sprite_row & (SPRITE_MSB >> j)) != '0) && (pc < WIDTH_LIM)) begin
        pattern[pc[COL_AW-1:0]] = 1'b1;
      end
    end
  end

  always_comb begin
    new_word = old_word;
    ctl      = '0;
    case (item.mode)
      MODE_DRAW: begin
        ctl.we       = tgt_ok;
        new_word     = old_word ^ pattern;
        ctl.done_res = item.last_row;
      end
      MODE_SET: begin
        ctl.we            = pix_ok;
        new_word[col_idx] = item.pixel_value;
      end
      MODE_INVERT: begin
        ctl.we            = pix_ok;
        new_word[col_idx] = ~old_word[col_idx];
      end
      MODE_READ: begin
        ctl.pixel_out = pix_ok & old_word[col_idx];
      end
      MODE_CLEAR: begin
        ctl.clr_all  = 1'b1;
        ctl.done_res = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/sprite_xor_framebuffer.sv
// Monochrome 1-bit-per-pixel framebuffer, SCREEN_WIDTH x SCREEN_HEIGHT, one row
// word per memory entry. Each input beat (mode in in_tuser, last sprite row in
// in_tlast) yields exactly one output beat: out_tdata[0] is the read pixel,
// out_tlast flags the end of a sprite draw or a completed clear. Items are
// processed one at a time: the row memory is read as the item is accepted in
// the idle state, then modify and write-back use its single write port in the
// modify state. A stalled output holds the block in the write-back state.
// Clear and reset take effect through per-row valid flags, so clear takes the
// same path as any other item and there is no clearing pass after reset.
`default_nettype none
module sprite_xor_framebuffer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // col[5:0], row[10:6], row_index[14:11], sprite_row[22:15], pixel_value[23]
  input  wire logic [sxfb_pkg::IN_TDATA_W-1:0]   in_tdata,
  // mode[2:0]
  input  wire logic [sxfb_pkg::MODE_W-1:0]       in_tuser,
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // pixel_out[0], zeros above
  output logic      [sxfb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                   out_tlast
);
  import sxfb_pkg::*;

  state_t state_r, state_nxt;
  item_t  item_r, item_nxt;
  item_t  in_item;

  logic [SCREEN_HEIGHT-1:0] valid_r, valid_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_pix_r, out_pix_nxt;
  logic                     out_done_r, out_done_nxt;

  logic                     in_fire;
  logic                     out_free;
  logic                     finish;

  logic [ROW_TGT_W-1:0]     in_tgt;
  logic [ROW_TGT_W-1:0]     cur_tgt;
  logic [ROW_AW-1:0]        rd_addr;
  logic [ROW_AW-1:0]        cur_addr;
  logic [SCREEN_WIDTH-1:0]  ram_rdata;
  logic [SCREEN_WIDTH-1:0]  old_word;
  logic [SCREEN_WIDTH-1:0]  new_word;
  logic                     ram_we;
  alu_ctl_t                 ctl;

  assign in_item = '{
    mode:        mode_t'(in_tuser),
    col:         in_tdata[5:0],
    row:         in_tdata[10:6],
    row_index:   in_tdata[14:11],
    sprite_row:  in_tdata[22:15],
    pixel_value: in_tdata[23],
    last_row:    in_tlast
  };

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign finish   = (state_r == ST_MODIFY) && out_free;

  assign in_tgt   = row_target(in_item);
  assign rd_addr  = in_tgt[ROW_AW-1:0];
  assign cur_tgt  = row_target(item_r);
  assign cur_addr = cur_tgt[ROW_AW-1:0];

  assign old_word = valid_r[cur_addr] ? ram_rdata : '0;
  assign ram_we   = finish && ctl.we;

  sxfb_ram #(
    .WIDTH (SCREEN_WIDTH),
    .DEPTH (SCREEN_HEIGHT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_addr),
    .wdata (new_word),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  sxfb_alu u_alu (
    .item     (item_r),
    .old_word (old_word),
    .new_word (new_word),
    .ctl      (ctl)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_MODIFY: in_tready = 1'b0;
      default:   in_tready = 1'b0;
    endcase
  end

  always_comb begin
    item_nxt      = in_fire ? in_item : item_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    out_done_nxt  = out_done_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      if (ctl.clr_all) begin
        valid_nxt = '0;
      end else if (ctl.we) begin
        valid_nxt[cur_addr] = 1'b1;
      end
      out_valid_nxt = 1'b1;
      out_pix_nxt   = ctl.pixel_out;
      out_done_nxt  = ctl.done_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_pix_r  <= out_pix_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_pix_r};
  assign out_tlast  = out_done_r;

`ifndef SYNTHESIS
  a_accept_to_modify: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_MODIFY)
    else $error("accepted beat did not enter modify");

  a_write_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_MODIFY) && out_free && !in_fire)
    else $error("row write outside finishing cycle");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && item_r.mode == MODE_CLEAR) |=> valid_r == '0 && out_tvalid && out_tlast)
    else $error("clear left rows valid or no done beat");
`endif

endmodule
`default_nettype wire
